@@ hdl/itdt_pkg.sv @@
// Shared types and constants for the integer to decimal text converter.
// No dependencies; used by every module of the block.
package itdt_pkg;

    localparam int MAX_CHARS_DEF = 16;

    localparam int VALUE_W = 33;
    localparam int MAG_W   = 32;
    localparam int CAP_W   = 5;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;
    localparam int MAXV_W  = 31;
    localparam int MINV_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MAX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MIN = 1'b1;

    localparam logic [MAXV_W-1:0] CLAMP_MAX_RST = 31'h7FFF_FFFF;
    localparam logic [MINV_W-1:0] CLAMP_MIN_RST = 32'h8000_0001;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;

    localparam logic [0:0] OP_FREE  = 1'b0;
    localparam logic [0:0] OP_FIXED = 1'b1;

    // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
    localparam int RADIX = 10;
    localparam logic [MAG_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;
    localparam int QUOT_W = 2 * MAG_W - RECIP_SHIFT;

    typedef struct packed {
        logic [MAXV_W-1:0] clamp_max;
        logic [MINV_W-1:0] clamp_min;
    } cfg_t;

endpackage

@@ hdl/integer_to_decimal_text_top.sv @@
// Top level of the integer to decimal text converter: sequencer and output stage.
// Depends on itdt_pkg, itdt_cfg_regs, itdt_div10, itdt_digit_buf.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    tuser: operation; tdata: value, capacity, digit_count
//  m_       out  m_tvalid/m_tready    tdata: character; tlast: last
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// Steps per request: take it; in the shared divide-by-ten unit, a multiply and a
// remainder step per digit (free form: magnitude digits, up to 10; fixed: digit_count,
// capped at MAX_CHARS); close; sign or lone zero slot; each digit given; end digits; NUL.
// Reset is synchronous on aresetn, clears control state and sets the limits to defaults.
// s_tready is low from acceptance until the NUL is in the output register;
// a stalled m_tready holds the character in place and pauses the output states.
module integer_to_decimal_text_top #(
    parameter int MAX_CHARS = itdt_pkg::MAX_CHARS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [32:0] value, [37:33] capacity, [42:38] digit_count
    input  logic [itdt_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] operation
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [6:0] character
    output logic [itdt_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [itdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [itdt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import itdt_pkg::*;

    localparam int IW = $clog2(MAX_CHARS);
    localparam int CW = $clog2(MAX_CHARS + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_REM, ST_PRE, ST_DIG, ST_NUL
    } state_t;

    cfg_t cfg;

    state_t            state_reg;
    logic              op_reg;
    logic              pf_reg;
    logic              neg_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [CW-1:0]     cnt_reg;
    logic [MAG_W-1:0]  x_reg;
    logic [CW-1:0]     dcnt_reg;
    logic [CW-1:0]     left_reg;
    logic [CW-1:0]     idx_reg;
    logic              m_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;

    logic signed [VALUE_W-1:0] v_in, lo_in, hi_in, vc, neg_mag;
    logic [MAG_W-1:0]  mag_in, u_in;
    logic              neg_in, pf_in;
    logic [CW-1:0]     cnt_in;
    logic [CAP_W-1:0]  cap_in, dcnt_in;

    logic              div_start;
    logic [MAG_W-1:0]  div_quot;
    logic [DIGIT_W-1:0] div_rem;
    logic [DIGIT_W-1:0] rd_digit;
    logic              conv_done;
    logic [CW-1:0]     room;
    logic              out_free;
    logic              dig_load;
    logic              out_load;
    logic [CW-1:0]     rd_idx;
    int                room_i, capsat_i, lim_i;

    itdt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    itdt_div10 u_div (
        .aclk  (aclk),
        .start (div_start),
        .x_in  (x_reg),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    itdt_digit_buf #(.WIDTH(DIGIT_W), .DEPTH(MAX_CHARS)) u_buf (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_REM),
        .wr_addr (dcnt_reg[IW-1:0]),
        .wr_data (div_rem),
        .rd_addr (rd_idx[IW-1:0]),
        .rd_data (rd_digit)
    );

    // input clamping
    always_comb begin
        v_in    = s_tdata[VALUE_W-1:0];
        cap_in  = s_tdata[VALUE_W+CAP_W-1:VALUE_W];
        dcnt_in = s_tdata[VALUE_W+2*CAP_W-1:VALUE_W+CAP_W];
        lo_in   = {cfg.clamp_min[MINV_W-1], cfg.clamp_min};
        hi_in   = {2'b00, cfg.clamp_max};
        neg_in  = v_in[VALUE_W-1];
        if (neg_in) begin
            vc = (v_in < lo_in) ? lo_in : v_in;
        end else begin
            vc = (v_in > hi_in) ? hi_in : v_in;
        end
        neg_mag = -vc;
        if (s_tuser == OP_FIXED) begin
            u_in   = v_in[MAG_W-1:0];
            mag_in = (u_in > {1'b0, cfg.clamp_max}) ? {1'b0, cfg.clamp_max} : u_in;
            pf_in  = 1'b0;
        end else begin
            u_in   = '0;
            if (neg_in) begin
                mag_in = neg_mag[VALUE_W-1] ? '0 : neg_mag[MAG_W-1:0];
            end else begin
                mag_in = vc[MAG_W-1:0];
            end
            pf_in  = neg_in || (vc == '0);
        end
        if ({27'd0, dcnt_in} > MAX_CHARS) begin
            cnt_in = CW'(MAX_CHARS);
        end else begin
            cnt_in = CW'(dcnt_in);
        end
    end

    // digits to emit once the division loop ends
    always_comb begin
        conv_done = (op_reg == OP_FIXED) ? (dcnt_reg == cnt_reg) : (x_reg == '0);
        capsat_i  = (int'(cap_reg) > int'(pf_reg)) ? int'(cap_reg) - int'(pf_reg) : 0;
        lim_i     = MAX_CHARS - int'(pf_reg);
        room_i    = int'(dcnt_reg);
        if (op_reg == OP_FREE) begin
            if (capsat_i < room_i) room_i = capsat_i;
            if (lim_i < room_i) room_i = lim_i;
        end
        room      = CW'(room_i);
    end

    assign div_start = (state_reg == ST_MUL) && !conv_done;
    assign out_free  = !m_valid_reg || m_tready;
    assign dig_load  = (state_reg == ST_DIG) && (left_reg != '0) && out_free;
    assign out_load  = ((state_reg == ST_PRE) && pf_reg && out_free) || dig_load
                       || ((state_reg == ST_NUL) && out_free);
    // read address runs one step ahead of the registered digit
    assign rd_idx    = dig_load ? idx_reg - CW'(1) : idx_reg;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_TDATA_W-CHAR_W){1'b0}}, char_reg};
    assign m_tlast   = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= s_tuser;
                        pf_reg    <= pf_in;
                        neg_reg   <= neg_in;
                        cap_reg   <= cap_in;
                        cnt_reg   <= cnt_in;
                        x_reg     <= mag_in;
                        dcnt_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (conv_done) begin
                        left_reg  <= room;
                        idx_reg   <= dcnt_reg - CW'(1);
                        state_reg <= ST_PRE;
                    end else begin
                        state_reg <= ST_REM;
                    end
                end
                ST_REM: begin
                    x_reg     <= div_quot;
                    dcnt_reg  <= dcnt_reg + CW'(1);
                    state_reg <= ST_MUL;
                end
                ST_PRE: begin
                    if (!pf_reg) begin
                        state_reg <= ST_DIG;
                    end else if (out_free) begin
                        m_valid_reg <= 1'b1;
                        char_reg    <= neg_reg ? CHAR_MINUS : CHAR_ZERO;
                        last_reg    <= 1'b0;
                        state_reg   <= ST_DIG;
                    end
                end
                ST_DIG: begin
                    if (left_reg == '0) begin
                        state_reg <= ST_NUL;
                    end else if (out_free) begin
                        m_valid_reg <= 1'b1;
                        char_reg    <= CHAR_ZERO + CHAR_W'(rd_digit);
                        last_reg    <= 1'b0;
                        left_reg    <= left_reg - CW'(1);
                        idx_reg     <= idx_reg - CW'(1);
                    end
                end
                ST_NUL: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        char_reg    <= CHAR_NUL;
                        last_reg    <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/itdt_cfg_regs.sv @@
// Configuration registers (clamp limits) of the decimal text converter.
// Depends on itdt_pkg.
module itdt_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [itdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [itdt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output itdt_pkg::cfg_t                   cfg
);
    import itdt_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clamp_max <= CLAMP_MAX_RST;
            cfg_reg.clamp_min <= CLAMP_MIN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CLAMP_MAX: cfg_reg.clamp_max <= cfg_data[MAXV_W-1:0];
                REG_CLAMP_MIN: cfg_reg.clamp_min <= cfg_data[MINV_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/itdt_div10.sv @@
// Shared divide-by-ten unit: reciprocal multiply, then quotient and remainder.
// Depends on itdt_pkg. Result valid the cycle after start.
module itdt_div10 (
    input  logic                             aclk,
    input  logic                             start,
    input  logic [itdt_pkg::MAG_W-1:0]       x_in,
    output logic [itdt_pkg::MAG_W-1:0]       quot,
    output logic [itdt_pkg::DIGIT_W-1:0]     rem
);
    import itdt_pkg::*;

    logic [MAG_W-1:0]   x_reg;
    logic [2*MAG_W-1:0] prod_reg;
    logic [QUOT_W-1:0]  q;
    logic [MAG_W-1:0]   diff;

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= x_in;
            prod_reg <= {{MAG_W{1'b0}}, x_in} * {{MAG_W{1'b0}}, RECIP_10};
        end
    end

    assign q    = prod_reg[2*MAG_W-1:RECIP_SHIFT];
    assign diff = x_reg - (MAG_W'(q) * MAG_W'(RADIX));
    assign quot = MAG_W'(q);
    assign rem  = diff[DIGIT_W-1:0];

endmodule

@@ hdl/itdt_digit_buf.sv @@
// Generic single-port-write RAM with registered read, used as the digit store.
// Depends on itdt_pkg for defaults; width and depth come from the instantiating module.
module itdt_digit_buf #(
    parameter int WIDTH = itdt_pkg::DIGIT_W,
    parameter int DEPTH = itdt_pkg::MAX_CHARS_DEF
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
